// ===== src/gif_frame_compositor_unit_assert.svh =====
// Assertion macros shared by the compositor RTL.
`ifndef GIF_FRAME_COMPOSITOR_UNIT_ASSERT_SVH
`define GIF_FRAME_COMPOSITOR_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define GFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/gfc_pkg.sv =====
// Types and constants of the GIF frame compositor.
package gfc_pkg;
  localparam int unsigned MaxCanvasWidth  = 256;
  localparam int unsigned MaxCanvasHeight = 256;
  localparam int unsigned PaletteDepth    = 256;
  localparam int unsigned StoreDepth      = MaxCanvasWidth * MaxCanvasHeight;
  localparam int unsigned AddrW           = $clog2(StoreDepth);
  localparam int unsigned PalW            = $clog2(PaletteDepth);
  localparam logic [7:0]  OpaqueAlpha     = 8'd255;

  typedef enum logic [2:0] {
    FUNC_CLEAR   = 3'd0,
    FUNC_START   = 3'd1,
    FUNC_PIXEL   = 3'd2,
    FUNC_PALETTE = 3'd3,
    FUNC_DISPOSE = 3'd4,
    FUNC_READ    = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_TRANSP  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DROPPED = 2'd3
  } status_e;

  localparam logic [2:0] DisposeClear   = 3'd2;
  localparam logic [2:0] DisposeRestore = 3'd3;

  typedef enum logic [3:0] {
    REG_CANVAS_WIDTH = 4'd0, REG_CANVAS_HEIGHT = 4'd1, REG_FRAME_LEFT = 4'd2,
    REG_FRAME_TOP = 4'd3, REG_FRAME_WIDTH = 4'd4, REG_FRAME_HEIGHT = 4'd5,
    REG_INTERLACED = 4'd6, REG_TRANSPARENT = 4'd7
  } reg_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  color_index;
    logic [23:0] palette_rgb;
    logic [8:0]  color_count;
    logic [2:0]  dispose_mode;
    logic [15:0] pixel_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        wrote;
    logic [15:0] written_address;
    logic [31:0] pixel_rgba;
  } out_item_t;

  function automatic logic [3:0] row_first(input logic [1:0] p);
    case (p)
      2'd0: row_first = 4'd0;
      2'd1: row_first = 4'd4;
      2'd2: row_first = 4'd2;
      default: row_first = 4'd1;
    endcase
  endfunction

  function automatic logic [3:0] row_step(input logic [1:0] p);
    case (p)
      2'd0, 2'd1: row_step = 4'd8;
      2'd2: row_step = 4'd4;
      default: row_step = 4'd2;
    endcase
  endfunction

  // Span of a rectangle edge clamped to a limit of at most 256.
  function automatic logic [8:0] clamp_span(input logic [15:0] start,
                                            input logic [15:0] size,
                                            input logic [8:0] limit);
    logic [16:0] room;
    room = {8'd0, limit} - {1'b0, start};
    if ({1'b0, start} >= {8'd0, limit}) clamp_span = 9'd0;
    else if ({1'b0, size} > room) clamp_span = room[8:0];
    else clamp_span = size[8:0];
  endfunction
endpackage

// ===== src/gfc_if.sv =====
// Valid/ready channel carrying one request or result.
interface gfc_in_if import gfc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gfc_out_if import gfc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/gif_frame_compositor_unit.sv =====
// A pixel or read request passes through S_PIXEL or S_READ before its result is offered in S_OUT;
// palette, copy-free start, empty dispose and unused codes go straight to S_OUT. One request is in
// flight at a time.
// Clear sweeps 65536 entries, start snapshot and restore sweep canvas width times height entries and
// rectangle clear its clamped width times height, one entry per cycle, before the result.
// Reset is asynchronous: control state clears at once, then a clearing pass over all 65536
// entries zeroes both canvases before the first request is taken.
`include "gif_frame_compositor_unit_assert.svh"
module gif_frame_compositor_unit import gfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  gfc_in_if.sink      in_ch,
  gfc_out_if.source   out_ch
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_COPY   = 7'b0000100,
    S_RECT   = 7'b0001000,
    S_PIXEL  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  logic [8:0]  cw_q, ch_q, tr_q;
  logic [15:0] fl_q, ft_q, fw_q, fh_q;
  logic        il_q;

  logic [31:0] canvas [StoreDepth];
  logic [31:0] saved  [StoreDepth];
  logic [23:0] palette [PaletteDepth];

  state_e      st_q, st_d;
  logic        init_q;
  logic [8:0]  psize_q;
  logic [16:0] rcount_q;
  logic [1:0]  pass_q;
  logic [8:0]  row_q, col_q;
  logic        fvalid_q;
  logic [15:0] ltop_q, lleft_q;
  logic [8:0]  lw_q, lh_q, lstride_q;
  logic        lil_q;
  logic [16:0] sweep_q;
  logic        dir_q;                 // copy direction: 1 canvas to saved
  logic [8:0]  rx_q, ry_q, rw_q, rh_q;
  out_item_t   res_q, res_d;
  in_item_t    req_q;
  logic [23:0] pal_rd_q;
  logic [31:0] cv_rd_q;
  logic [31:0] cp_rd_q;
  logic        cp_we_q;
  logic [15:0] cp_addr_q;
  logic [16:0] area_q;
  logic [15:0] pix_addr_q;
  logic        pix_oob_q;
  logic [8:0]  cw_e, ch_e;

  assign cw_e = (cw_q > 9'(MaxCanvasWidth)) ? 9'(MaxCanvasWidth) : cw_q;
  assign ch_e = (ch_q > 9'(MaxCanvasHeight)) ? 9'(MaxCanvasHeight) : ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 9'd256; ch_q <= 9'd256; tr_q <= 9'd256;
      fl_q <= '0; ft_q <= '0; fw_q <= '0; fh_q <= '0; il_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CANVAS_WIDTH:  cw_q <= cfg_data_i[8:0];
        REG_CANVAS_HEIGHT: ch_q <= cfg_data_i[8:0];
        REG_FRAME_LEFT:    fl_q <= cfg_data_i;
        REG_FRAME_TOP:     ft_q <= cfg_data_i;
        REG_FRAME_WIDTH:   fw_q <= cfg_data_i;
        REG_FRAME_HEIGHT:  fh_q <= cfg_data_i;
        REG_INTERLACED:    il_q <= cfg_data_i[0];
        REG_TRANSPARENT:   tr_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign in_ch.ready  = (st_q == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (st_q == S_OUT);
  assign out_ch.data  = res_q;

  // Frame geometry decode for the start, dispose and pixel requests.
  logic [8:0]  cl_w, cl_h;
  logic [16:0] area_c, lim_c;
  assign cl_w   = clamp_span(fl_q, fw_q, cw_e);
  assign cl_h   = clamp_span(ft_q, fh_q, ch_e);
  assign area_c = 17'(cw_e * ch_e);
  assign lim_c  = 17'(lw_q * lh_q);

  // Pixel address and next raster position.
  logic [24:0] pa_full;
  logic [8:0]  col_n, row_n;
  logic [1:0]  pass_n;
  logic [12:0] row_t;
  assign pa_full = 25'((ltop_q + {7'd0, row_q}) * lstride_q) + 25'(lleft_q) + 25'(col_q);

  always_comb begin
    col_n  = col_q + 9'd1;
    row_n  = row_q;
    pass_n = pass_q;
    row_t  = '0;
    if (col_n >= lw_q) begin
      col_n = '0;
      row_t = 13'(row_q) + (lil_q ? 13'(row_step(pass_q)) : 13'd1);
      // At most three pass changes, each a compare of narrow values.
      if (lil_q) begin
        for (int i = 0; i < 3; i++) begin
          if (row_t >= 13'(lh_q) && pass_n < 2'd3) begin
            pass_n = pass_n + 2'd1;
            row_t  = 13'(row_first(pass_n));
          end
        end
      end
      row_n = row_t[8:0];
    end
  end

  logic [16:0] rect_addr;
  assign rect_addr = 17'((ft_q[8:0] + ry_q) * cw_e) + 17'(fl_q[8:0]) + 17'(rx_q);

  // Pixel checks, made in the cycle after the palette lookup.
  logic transp_hit, range_hit, pix_we;
  assign transp_hit = (req_q.color_index == tr_q[7:0]) && !tr_q[8];
  assign range_hit  = ({1'b0, req_q.color_index} >= psize_q);
  assign pix_we     = (st_q == S_PIXEL) && res_q.wrote && !transp_hit && !range_hit &&
                      !pix_oob_q;

  always_ff @(posedge clk_i) begin
    pal_rd_q <= palette[in_ch.data.color_index];
    cv_rd_q  <= canvas[in_ch.data.pixel_address];
    // Copies read one entry per cycle and write it back in the next cycle.
    cp_rd_q  <= dir_q ? canvas[sweep_q[15:0]] : saved[sweep_q[15:0]];
    if (accept && in_ch.data.func == FUNC_PALETTE)
      palette[in_ch.data.color_index] <= in_ch.data.palette_rgb;
    if (st_q == S_CLEAR) begin
      canvas[sweep_q[15:0]] <= '0;
      saved[sweep_q[15:0]]  <= '0;
    end
    if (cp_we_q) begin
      if (dir_q) saved[cp_addr_q] <= cp_rd_q;
      else canvas[cp_addr_q] <= cp_rd_q;
    end
    if (st_q == S_RECT) canvas[rect_addr[15:0]] <= '0;
    if (pix_we) canvas[pix_addr_q] <= {pal_rd_q, OpaqueAlpha};
    if (accept) req_q <= in_ch.data;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (accept) begin
        unique case (in_ch.data.func)
          FUNC_CLEAR:   st_d = S_CLEAR;
          FUNC_START:   st_d = (cl_w == '0 || cl_h == '0 || area_c == '0) ? S_OUT : S_COPY;
          FUNC_PIXEL:   st_d = S_PIXEL;
          FUNC_DISPOSE: begin
            if (in_ch.data.dispose_mode == DisposeClear)
              st_d = (cl_w == '0 || cl_h == '0) ? S_OUT : S_RECT;
            else if (in_ch.data.dispose_mode == DisposeRestore && area_c != '0) st_d = S_COPY;
            else st_d = S_OUT;
          end
          FUNC_READ:    st_d = S_READ;
          default:      st_d = S_OUT;
        endcase
      end
      // The clearing pass after reset has no request behind it and gives no result.
      S_CLEAR: if (sweep_q == 17'(StoreDepth - 1)) st_d = init_q ? S_IDLE : S_OUT;
      S_COPY:  if (sweep_q + 17'd1 >= area_q) st_d = S_OUT;
      S_RECT:  if (rx_q + 9'd1 >= rw_q && ry_q + 9'd1 >= rh_q) st_d = S_OUT;
      S_PIXEL: st_d = S_OUT;
      S_READ:  st_d = S_OUT;
      S_OUT:   if (out_ch.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d = res_q;
    if (st_q == S_READ) begin
      if ((req_q.pixel_address >= area_q[15:0] && area_q != 17'(StoreDepth)) ||
          area_q == '0)
        res_d.status = ST_DROPPED;
      else res_d.pixel_rgba = cv_rd_q;
    end
    if (st_q == S_PIXEL && res_q.wrote) begin
      if (transp_hit || range_hit || pix_oob_q) begin
        res_d.status = transp_hit ? ST_TRANSP : range_hit ? ST_RANGE : ST_DROPPED;
        res_d.wrote = 1'b0;
        res_d.written_address = '0;
      end else begin
        res_d.pixel_rgba = {pal_rd_q, OpaqueAlpha};
      end
    end
    if (accept) begin
      res_d = '0;
      if (in_ch.data.func == FUNC_START && (cl_w == '0 || cl_h == '0))
        res_d.status = ST_DROPPED;
      if (in_ch.data.func == FUNC_PIXEL) begin
        if (!fvalid_q || rcount_q >= lim_c) res_d.status = ST_DROPPED;
        else begin
          res_d.wrote = 1'b1;
          res_d.written_address = pa_full[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; init_q <= 1'b1; sweep_q <= '0; psize_q <= 9'(PaletteDepth);
      rcount_q <= '0; pass_q <= '0; row_q <= '0; col_q <= '0; fvalid_q <= 1'b0;
      ltop_q <= '0; lleft_q <= '0; lw_q <= '0; lh_q <= '0; lstride_q <= '0; lil_q <= 1'b0;
      dir_q <= 1'b0; rx_q <= '0; ry_q <= '0; rw_q <= '0; rh_q <= '0; area_q <= '0;
      res_q <= '0; pix_addr_q <= '0; pix_oob_q <= 1'b0; cp_we_q <= 1'b0; cp_addr_q <= '0;
    end else begin
      st_q <= st_d;
      res_q <= res_d;
      cp_we_q <= (st_q == S_COPY);
      cp_addr_q <= sweep_q[15:0];
      if (st_q == S_CLEAR && sweep_q == 17'(StoreDepth - 1)) init_q <= 1'b0;
      if (st_q == S_CLEAR || st_q == S_COPY) sweep_q <= sweep_q + 17'd1;
      if (st_q == S_RECT) begin
        if (rx_q + 9'd1 >= rw_q) begin
          rx_q <= '0; ry_q <= ry_q + 9'd1;
        end else rx_q <= rx_q + 9'd1;
      end
      if (accept) begin
        sweep_q <= '0; area_q <= area_c;
        unique case (in_ch.data.func)
          FUNC_START: begin
            psize_q <= (in_ch.data.color_count > 9'(PaletteDepth)) ? 9'(PaletteDepth)
                                                                   : in_ch.data.color_count;
            rcount_q <= '0; pass_q <= '0; row_q <= '0; col_q <= '0;
            ltop_q <= ft_q; lleft_q <= fl_q; lw_q <= cl_w; lh_q <= cl_h;
            lstride_q <= cw_e; lil_q <= il_q; dir_q <= 1'b1;
            fvalid_q <= !(cl_w == '0 || cl_h == '0);
          end
          FUNC_PIXEL: begin
            if (fvalid_q && rcount_q < lim_c) begin
              rcount_q <= rcount_q + 17'd1;
              col_q <= col_n; row_q <= row_n; pass_q <= pass_n;
              pix_addr_q <= pa_full[15:0];
              pix_oob_q <= (pa_full >= 25'(StoreDepth));
            end
          end
          FUNC_DISPOSE: begin
            dir_q <= 1'b0; rx_q <= '0; ry_q <= '0; rw_q <= cl_w; rh_q <= cl_h;
          end
          default: ;
        endcase
      end
    end
  end

  // The palette lookup is issued on accept, the write happens in the next cycle.
  `GFC_ASSERT_NEXT(a_pix_one, clk_i, rst_ni, st_q == S_PIXEL, st_q == S_OUT)
  `GFC_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != S_IDLE, !in_ch.ready)
  `GFC_ASSERT_IMP(a_wrote_done, clk_i, rst_ni, out_ch.valid && res_q.wrote,
                  res_q.status == ST_DONE)
  `GFC_ASSERT_IMP(a_frame_geom, clk_i, rst_ni, fvalid_q, lw_q != '0 && lh_q != '0)
endmodule
